[hw/rtl/ipv4hb_pkg.sv]
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Shared types and constants of the IPv4 header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hb_pkg;

	localparam int HDR_BYTES   = 20;
	localparam int IDX_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int PADDR_W     = 5;
	localparam int ACC_W       = 20;

	localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
	localparam logic [7:0]  VER_IHL     = 8'h45;

	// input command codes
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	// queue entry kinds
	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// register indexes
	localparam logic [2:0] REG_SRC_ADDR     = 3'd0;
	localparam logic [2:0] REG_DST_ADDR     = 3'd1;
	localparam logic [2:0] REG_PROTO_NUM    = 3'd2;
	localparam logic [2:0] REG_TIME_TO_LIVE = 3'd3;
	localparam logic [2:0] REG_SERVICE_TYPE = 3'd4;
	localparam logic [2:0] REG_FRAG_FLAGS   = 3'd5;
	localparam logic [2:0] REG_IDENT        = 3'd6;
	localparam logic [2:0] REG_FRAG_OFFSET  = 3'd7;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  proto_num;
		logic [7:0]  time_to_live;
		logic [7:0]  service_type;
		logic [2:0]  frag_flags;
		logic [15:0] ident;
		logic [12:0] frag_offset;
	} cfg_t;

	// one classified item: a header request (data = total length) or a byte
	typedef struct packed {
		logic        kind;
		logic [15:0] data;
		logic        last;
	} qent_t;

endpackage

`default_nettype wire

[hw/rtl/ipv4_header_builder.sv]
// ----------------------------------------------------------------------------
// ipv4_header_builder
// Builds a 20-byte IPv4 header with checksum, then passes the payload bytes.
// ----------------------------------------------------------------------------
// A start item (cmd 0) carries the payload length, saturated to 65515; the
// block answers with a 20-byte IPv4 header in network order (version 4, IHL
// 5, the configured fields, total length 20 plus payload, ones' complement
// checksum at bytes 10-11). Payload items (cmd 1) then pass through one byte
// each until the announced count is sent; last marks the final byte of the
// packet, or header byte 19 for an empty payload. Payload bytes arriving
// while none are expected are dropped, and a start arriving early abandons
// the unfinished packet. A payload item gives one byte, a start item
// twenty, one byte per cycle unless stalled, from a single output register.
// The front accepts items into a four-entry queue, so input keeps flowing
// one item per cycle while the queue has room; it stalls during a header
// burst once the queue fills. An accepted item is written to a queue slot,
// then its first byte to the output register. The checksum is accumulated
// one word per header byte, folded at byte 9, so no wide adder tree sits in
// any path. Write the APB registers only while the block is idle.
`default_nettype none

module ipv4_header_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           cmd,
	input  wire logic [15:0]                    payload_length,
	input  wire logic [7:0]                     payload_byte,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [7:0]                     out_byte,
	output logic                                last,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ipv4hb_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready
);

	ipv4hb_pkg::cfg_t  cfg;
	ipv4hb_pkg::qent_t push_ent;
	ipv4hb_pkg::qent_t head;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;

	// hold the input whenever the queue has no room
	assign in_stall = q_full;

	ipv4hb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: classify each item, count payload, drop strays
	ipv4hb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.push           (push),
		.push_ent       (push_ent)
	);

	// queue: decouple acceptance from emission
	ipv4hb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: expand header entries into bytes, advance one byte per cycle unless out_stall
	ipv4hb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

`default_nettype wire

[hw/rtl/ipv4hb_regs.sv]
// ----------------------------------------------------------------------------
// ipv4hb_regs
// APB register file holding the configured header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ipv4hb_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output ipv4hb_pkg::cfg_t                   cfg
);

	ipv4hb_pkg::cfg_t cfg_q;
	logic [2:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[ipv4hb_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_addr     <= 32'd0;
			cfg_q.dst_addr     <= 32'd0;
			cfg_q.proto_num    <= 8'd1;
			cfg_q.time_to_live <= 8'd64;
			cfg_q.service_type <= 8'd0;
			cfg_q.frag_flags   <= 3'd2;
			cfg_q.ident        <= 16'd0;
			cfg_q.frag_offset  <= 13'd0;
		end else if (wr_en) begin
			case (reg_idx)
				ipv4hb_pkg::REG_SRC_ADDR:     cfg_q.src_addr     <= pwdata;
				ipv4hb_pkg::REG_DST_ADDR:     cfg_q.dst_addr     <= pwdata;
				ipv4hb_pkg::REG_PROTO_NUM:    cfg_q.proto_num    <= pwdata[7:0];
				ipv4hb_pkg::REG_TIME_TO_LIVE: cfg_q.time_to_live <= pwdata[7:0];
				ipv4hb_pkg::REG_SERVICE_TYPE: cfg_q.service_type <= pwdata[7:0];
				ipv4hb_pkg::REG_FRAG_FLAGS:   cfg_q.frag_flags   <= pwdata[2:0];
				ipv4hb_pkg::REG_IDENT:        cfg_q.ident        <= pwdata[15:0];
				ipv4hb_pkg::REG_FRAG_OFFSET:  cfg_q.frag_offset  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ipv4hb_pkg::REG_SRC_ADDR:     prdata = cfg_q.src_addr;
			ipv4hb_pkg::REG_DST_ADDR:     prdata = cfg_q.dst_addr;
			ipv4hb_pkg::REG_PROTO_NUM:    prdata = {24'd0, cfg_q.proto_num};
			ipv4hb_pkg::REG_TIME_TO_LIVE: prdata = {24'd0, cfg_q.time_to_live};
			ipv4hb_pkg::REG_SERVICE_TYPE: prdata = {24'd0, cfg_q.service_type};
			ipv4hb_pkg::REG_FRAG_FLAGS:   prdata = {29'd0, cfg_q.frag_flags};
			ipv4hb_pkg::REG_IDENT:        prdata = {16'd0, cfg_q.ident};
			ipv4hb_pkg::REG_FRAG_OFFSET:  prdata = {19'd0, cfg_q.frag_offset};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/ipv4hb_front.sv]
// ----------------------------------------------------------------------------
// ipv4hb_front
// Accepts input items, tracks the expected payload count and classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        cmd,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  payload_byte,
	output logic             push,
	output ipv4hb_pkg::qent_t push_ent
);

	logic [15:0] rem_q;
	logic [15:0] plen_sat;
	logic        accept;

	assign accept   = in_valid && !in_stall;
	assign plen_sat = (payload_length > ipv4hb_pkg::MAX_PAYLOAD) ?
		ipv4hb_pkg::MAX_PAYLOAD : payload_length;

	always_comb begin
		push_ent = '0;
		push     = 1'b0;
		if (cmd == ipv4hb_pkg::CMD_START) begin
			push_ent.kind = ipv4hb_pkg::KIND_HDR;
			push_ent.data = plen_sat + 16'(ipv4hb_pkg::HDR_BYTES);
			push_ent.last = (plen_sat == 16'd0);
			push          = accept;
		end else begin
			push_ent.kind = ipv4hb_pkg::KIND_DATA;
			push_ent.data = {8'd0, payload_byte};
			push_ent.last = (rem_q == 16'd1);
			// drop stray bytes
			push          = accept && (rem_q != 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 16'd0;
		end else if (accept) begin
			if (cmd == ipv4hb_pkg::CMD_START) begin
				rem_q <= plen_sat;
			end else if (rem_q != 16'd0) begin
				rem_q <= rem_q - 16'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ipv4hb_queue.sv]
// ----------------------------------------------------------------------------
// ipv4hb_queue
// Small FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ipv4hb_pkg::qent_t push_ent,
	input  wire logic              pop,
	output ipv4hb_pkg::qent_t      head,
	output logic                   empty,
	output logic                   full
);

	ipv4hb_pkg::qent_t               slot_q [ipv4hb_pkg::QUEUE_DEPTH];
	logic [ipv4hb_pkg::QPTR_W-1:0]   wptr_q;
	logic [ipv4hb_pkg::QPTR_W-1:0]   rptr_q;
	logic [ipv4hb_pkg::QCNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == ipv4hb_pkg::QCNT_W'(ipv4hb_pkg::QUEUE_DEPTH));
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ipv4hb_pkg::QCNT_W'(ipv4hb_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

[hw/rtl/ipv4hb_back.sv]
// ----------------------------------------------------------------------------
// ipv4hb_back
// Emits header bytes with a running checksum, and passes payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ipv4hb_pkg::cfg_t  cfg,
	input  wire ipv4hb_pkg::qent_t head,
	input  wire logic              empty,
	output logic                   pop,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [7:0]             out_byte,
	output logic                   last
);

	logic [ipv4hb_pkg::IDX_W-1:0] idx_q;
	logic [ipv4hb_pkg::ACC_W-1:0] acc_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         last_q;

	logic                         take;
	logic                         is_hdr;
	logic                         hdr_end;
	logic [15:0]                  word;
	logic [16:0]                  fold1;
	logic [15:0]                  csum;
	logic [7:0]                   hdr_byte;

	assign take    = !empty && (!out_valid_q || !out_stall);
	assign is_hdr  = (head.kind == ipv4hb_pkg::KIND_HDR);
	assign hdr_end = (idx_q == ipv4hb_pkg::IDX_W'(ipv4hb_pkg::HDR_BYTES - 1));
	assign pop     = take && (!is_hdr || hdr_end);

	// checksum word added while header byte idx_q goes out
	always_comb begin
		case (idx_q)
			5'd0:    word = {ipv4hb_pkg::VER_IHL, cfg.service_type};
			5'd1:    word = head.data;
			5'd2:    word = cfg.ident;
			5'd3:    word = {cfg.frag_flags, cfg.frag_offset};
			5'd4:    word = {cfg.time_to_live, cfg.proto_num};
			5'd5:    word = cfg.src_addr[31:16];
			5'd6:    word = cfg.src_addr[15:0];
			5'd7:    word = cfg.dst_addr[31:16];
			5'd8:    word = cfg.dst_addr[15:0];
			default: word = 16'd0;
		endcase
	end

	assign fold1 = {1'b0, acc_q[15:0]} + {13'd0, acc_q[19:16]};
	assign csum  = ~(acc_q[15:0] + {15'd0, acc_q[16]});

	always_comb begin
		case (idx_q)
			5'd0:    hdr_byte = ipv4hb_pkg::VER_IHL;
			5'd1:    hdr_byte = cfg.service_type;
			5'd2:    hdr_byte = head.data[15:8];
			5'd3:    hdr_byte = head.data[7:0];
			5'd4:    hdr_byte = cfg.ident[15:8];
			5'd5:    hdr_byte = cfg.ident[7:0];
			5'd6:    hdr_byte = {cfg.frag_flags, cfg.frag_offset[12:8]};
			5'd7:    hdr_byte = cfg.frag_offset[7:0];
			5'd8:    hdr_byte = cfg.time_to_live;
			5'd9:    hdr_byte = cfg.proto_num;
			5'd10:   hdr_byte = csum[15:8];
			5'd11:   hdr_byte = acc_q[7:0];
			5'd12:   hdr_byte = cfg.src_addr[31:24];
			5'd13:   hdr_byte = cfg.src_addr[23:16];
			5'd14:   hdr_byte = cfg.src_addr[15:8];
			5'd15:   hdr_byte = cfg.src_addr[7:0];
			5'd16:   hdr_byte = cfg.dst_addr[31:24];
			5'd17:   hdr_byte = cfg.dst_addr[23:16];
			5'd18:   hdr_byte = cfg.dst_addr[15:8];
			5'd19:   hdr_byte = cfg.dst_addr[7:0];
			default: hdr_byte = 8'd0;
		endcase
	end

	// accumulate, fold, then hold the final checksum for its low byte
	always_ff @(posedge clk) begin
		if (take && is_hdr) begin
			if (idx_q == 5'd0) begin
				acc_q <= {4'd0, word};
			end else if (idx_q <= 5'd8) begin
				acc_q <= acc_q + {4'd0, word};
			end else if (idx_q == 5'd9) begin
				acc_q <= {3'd0, fold1};
			end else if (idx_q == 5'd10) begin
				acc_q <= {4'd0, csum};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take && is_hdr) begin
			idx_q <= hdr_end ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= is_hdr ? hdr_byte : head.data[7:0];
			last_q     <= is_hdr ? (hdr_end && head.last) : head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= ipv4hb_pkg::IDX_W'(ipv4hb_pkg::HDR_BYTES - 1))
		else $error("header index beyond last byte");
	a_hdr_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> (!empty && is_hdr))
		else $error("header in progress without its queue entry");
`endif

endmodule

`default_nettype wire

[tb/ipv4_header_builder_test.sv]
// ----------------------------------------------------------------------------
// ipv4_header_builder_test
// Self-checking bench for the IPv4 header builder.
// ----------------------------------------------------------------------------
// The bench starts with a short table of directed items: stray bytes, empty
// and saturated lengths, and early restarts. A few of the header rows are
// typed in by hand. It then runs eight phases of random packet traffic. Each
// phase has its own register setting (all ones, all zeros or random) and its
// own idle pattern on the input and output channels. Every accepted item
// runs through a local header and checksum builder, and each output byte is
// compared with the oldest byte that builder queued.
// ----------------------------------------------------------------------------

module ipv4_header_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one byte on the wire, as the output channel should show it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	// one row of the directed table; known rows carry a hand-typed header
	typedef struct packed {
		logic         c;
		logic [15:0]  len;
		logic [7:0]   pb;
		logic         known;
		logic [159:0] hdr;
	} stim_row_t;

	localparam int DIR_ROWS = 24;

	// reset settings, payload length 0: total 20, checksum 3AEA
	localparam logic [159:0] HDR_RESET_EMPTY =
		160'h45000014_00004000_40013AEA_00000000_00000000;
	// reset settings, length saturated to 65515: total FFFF, checksum 3AFE
	localparam logic [159:0] HDR_RESET_FULL =
		160'h4500FFFF_00004000_40013AFE_00000000_00000000;

	logic                           clk;
	logic                           arst_n         = 1'b0;
	logic                           in_valid       = 1'b0;
	logic                           cmd            = ipv4hb_pkg::CMD_START;
	logic [15:0]                    payload_length = '0;
	logic [7:0]                     payload_byte   = '0;
	logic                           out_stall      = 1'b0;
	logic                           psel           = 1'b0;
	logic                           penable        = 1'b0;
	logic                           pwrite         = 1'b0;
	logic [ipv4hb_pkg::PADDR_W-1:0] paddr          = '0;
	logic [31:0]                    pwdata         = '0;
	logic                           in_stall;
	logic                           out_valid;
	logic [7:0]                     out_byte;
	logic                           last;
	logic [31:0]                    prdata;
	logic                           pready;

	// register shadow and payload count of the local builder
	ipv4hb_pkg::cfg_t    hdr_cfg;
	logic [15:0]         bytes_left;
	wire_byte_t          wire_bytes[$];
	stim_row_t           dir_tab[DIR_ROWS];

	int                  err_cnt       = 0;
	int                  items_done    = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct     = 0;

	ipv4_header_builder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last           (last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sum the ten header words with the checksum word as zero, fold the
	// carries back until none is left, and complement.
	function automatic logic [15:0] ip_checksum(logic [15:0] total);
		logic [31:0] acc;
		acc = {16'd0, ipv4hb_pkg::VER_IHL, hdr_cfg.service_type};
		acc += total;
		acc += hdr_cfg.ident;
		acc += {hdr_cfg.frag_flags, hdr_cfg.frag_offset};
		acc += {hdr_cfg.time_to_live, hdr_cfg.proto_num};
		acc += hdr_cfg.src_addr[31:16];
		acc += hdr_cfg.src_addr[15:0];
		acc += hdr_cfg.dst_addr[31:16];
		acc += hdr_cfg.dst_addr[15:0];
		while (acc[31:16] != 16'd0)
			acc = acc[15:0] + acc[31:16];
		return ~acc[15:0];
	endfunction

	// Queue the bytes that one accepted item should cause on the output.
	function automatic void build_wire_bytes(logic c, logic [15:0] len, logic [7:0] pb,
			logic known, logic [159:0] typed);
		logic [15:0]  plen;
		logic [15:0]  total;
		logic [159:0] hdr;
		wire_byte_t   wb;
		if (c == ipv4hb_pkg::CMD_START) begin
			plen  = (len > ipv4hb_pkg::MAX_PAYLOAD) ? ipv4hb_pkg::MAX_PAYLOAD : len;
			total = plen + 16'(ipv4hb_pkg::HDR_BYTES);
			hdr   = {ipv4hb_pkg::VER_IHL, hdr_cfg.service_type, total, hdr_cfg.ident,
				hdr_cfg.frag_flags, hdr_cfg.frag_offset, hdr_cfg.time_to_live,
				hdr_cfg.proto_num, ip_checksum(total), hdr_cfg.src_addr,
				hdr_cfg.dst_addr};
			if (known)
				hdr = typed;
			for (int i = 0; i < ipv4hb_pkg::HDR_BYTES; i++) begin
				wb.data = hdr[159 - 8 * i -: 8];
				wb.last = (i == ipv4hb_pkg::HDR_BYTES - 1) && (plen == 16'd0);
				wire_bytes = {wire_bytes, wb};
			end
			// an early start simply overwrites the unfinished count
			bytes_left = plen;
			items_done++;
		end else if (bytes_left != 16'd0) begin
			bytes_left = bytes_left - 16'd1;
			wb.data    = pb;
			wb.last    = (bytes_left == 16'd0);
			wire_bytes = {wire_bytes, wb};
			items_done++;
		end
		// stray payload with nothing expected: drop, no bytes queued
	endfunction

	function automatic stim_row_t row(logic c, logic [15:0] len, logic [7:0] pb,
			logic known, logic [159:0] hdr);
		stim_row_t r;
		r.c     = c;
		r.len   = len;
		r.pb    = pb;
		r.known = known;
		r.hdr   = hdr;
		return r;
	endfunction

	function automatic logic [31:0] cfg_value(int kind);
		case (kind)
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Offer one item, idling first as the phase asks, and hold it until the
	// block takes it. Valid stays high on return so back-to-back items flow.
	task automatic drive_item(logic c, logic [15:0] len, logic [7:0] pb,
			logic known, logic [159:0] typed);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		payload_length <= len;
		payload_byte   <= pb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		build_wire_bytes(c, len, pb, known, typed);
	endtask

	// Drop valid and hold off until every queued byte has come out, then let
	// the block settle before returning.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (wire_bytes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where the access cycle sees pready. Then psel drops before returning.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			ipv4hb_pkg::REG_SRC_ADDR:     hdr_cfg.src_addr     = val;
			ipv4hb_pkg::REG_DST_ADDR:     hdr_cfg.dst_addr     = val;
			ipv4hb_pkg::REG_PROTO_NUM:    hdr_cfg.proto_num    = val[7:0];
			ipv4hb_pkg::REG_TIME_TO_LIVE: hdr_cfg.time_to_live = val[7:0];
			ipv4hb_pkg::REG_SERVICE_TYPE: hdr_cfg.service_type = val[7:0];
			ipv4hb_pkg::REG_FRAG_FLAGS:   hdr_cfg.frag_flags   = val[2:0];
			ipv4hb_pkg::REG_IDENT:        hdr_cfg.ident        = val[15:0];
			ipv4hb_pkg::REG_FRAG_OFFSET:  hdr_cfg.frag_offset  = val[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(int kind);
		reg_write(ipv4hb_pkg::REG_SRC_ADDR,     cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_DST_ADDR,     cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_PROTO_NUM,    cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_TIME_TO_LIVE, cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_SERVICE_TYPE, cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_FRAG_FLAGS,   cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_IDENT,        cfg_value(kind));
		reg_write(ipv4hb_pkg::REG_FRAG_OFFSET,  cfg_value(kind));
	endtask

	// Mostly well-formed packets with short payloads; the rest is stray
	// bytes, truncated packets and huge lengths cut short by the next start.
	task automatic run_traffic(int n);
		int          base;
		int          r;
		int          n_pay;
		logic [15:0] len;
		base = items_done;
		while (items_done - base < n) begin
			r = $urandom_range(99);
			if (r < 8) begin
				drive_item(ipv4hb_pkg::CMD_PAYLOAD, 16'($urandom), 8'($urandom), 1'b0, '0);
			end else begin
				if (r < 70)
					len = 16'($urandom_range(6));
				else if (r < 90)
					len = 16'($urandom_range(40, 7));
				else
					len = 16'($urandom);
				n_pay = len;
				if (len > 16'd40)
					n_pay = $urandom_range(5);
				else if ($urandom_range(9) == 0)
					n_pay = $urandom_range(len);
				drive_item(ipv4hb_pkg::CMD_START, len, 8'($urandom), 1'b0, '0);
				repeat (n_pay)
					drive_item(ipv4hb_pkg::CMD_PAYLOAD, 16'($urandom), 8'($urandom),
						1'b0, '0);
			end
		end
	endtask

	// Receiver: stall at the rate the phase asks.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Check every accepted output byte against the oldest queued one.
	always @(posedge clk) begin
		wire_byte_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (wire_bytes.size() == 0) begin
				$error("unexpected output: out_byte %h last %b", out_byte, last);
				err_cnt++;
			end else begin
				want = wire_bytes.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					err_cnt++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		hdr_cfg.src_addr     = '0;
		hdr_cfg.dst_addr     = '0;
		hdr_cfg.proto_num    = 8'd1;
		hdr_cfg.time_to_live = 8'd64;
		hdr_cfg.service_type = '0;
		hdr_cfg.frag_flags   = 3'd2;
		hdr_cfg.ident        = '0;
		hdr_cfg.frag_offset  = '0;
		bytes_left           = '0;

		// directed rows, all at reset settings
		// stray after reset, then stray with all ones
		dir_tab[0]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h00, 1'b0, '0);
		dir_tab[1]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'hFFFF, 8'hFF, 1'b0, '0);
		dir_tab[2]  = row(ipv4hb_pkg::CMD_START,   16'd0,    8'h00, 1'b1, HDR_RESET_EMPTY);
		// stray after empty
		dir_tab[3]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h5A, 1'b0, '0);
		dir_tab[4]  = row(ipv4hb_pkg::CMD_START,   16'hFFFF, 8'hFF, 1'b1, HDR_RESET_FULL);
		dir_tab[5]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'hFF, 1'b0, '0);
		dir_tab[6]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'hFFFF, 8'h00, 1'b0, '0);
		dir_tab[7]  = row(ipv4hb_pkg::CMD_START,   16'd65515, 8'h00, 1'b1, HDR_RESET_FULL);
		dir_tab[8]  = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h1234, 8'h81, 1'b0, '0);
		// early start
		dir_tab[9]  = row(ipv4hb_pkg::CMD_START,   16'd1,    8'h00, 1'b0, '0);
		dir_tab[10] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'hA5, 1'b0, '0);
		// stray
		dir_tab[11] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h3C, 1'b0, '0);
		dir_tab[12] = row(ipv4hb_pkg::CMD_START,   16'd3,    8'h7E, 1'b0, '0);
		dir_tab[13] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h01, 1'b0, '0);
		dir_tab[14] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h80, 1'b0, '0);
		dir_tab[15] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'hFE, 1'b0, '0);
		dir_tab[16] = row(ipv4hb_pkg::CMD_START,   16'd65516, 8'h00, 1'b1, HDR_RESET_FULL);
		// early start
		dir_tab[17] = row(ipv4hb_pkg::CMD_START,   16'd2,    8'h00, 1'b0, '0);
		dir_tab[18] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h11, 1'b0, '0);
		dir_tab[19] = row(ipv4hb_pkg::CMD_START,   16'd0,    8'h00, 1'b1, HDR_RESET_EMPTY);
		dir_tab[20] = row(ipv4hb_pkg::CMD_START,   16'h8000, 8'h00, 1'b0, '0);
		dir_tab[21] = row(ipv4hb_pkg::CMD_START,   16'h7FFF, 8'hC3, 1'b0, '0);
		dir_tab[22] = row(ipv4hb_pkg::CMD_START,   16'd1,    8'h00, 1'b0, '0);
		dir_tab[23] = row(ipv4hb_pkg::CMD_PAYLOAD, 16'h0000, 8'h00, 1'b0, '0);

		// hold reset, then release on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			drive_item(dir_tab[i].c, dir_tab[i].len, dir_tab[i].pb,
				dir_tab[i].known, dir_tab[i].hdr);
		wait_drained();

		// random phases; config and idle pattern change only while drained
		for (int p = 0; p < 8; p++) begin
			set_config(p % 3);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			run_traffic(11);
			// pause mid-phase once until the output has caught up
			if (p == 3)
				wait_drained();
			run_traffic(11);
			wait_drained();
		end

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ipv4hb_pkg.sv
hw/rtl/ipv4hb_regs.sv
hw/rtl/ipv4hb_front.sv
hw/rtl/ipv4hb_queue.sv
hw/rtl/ipv4hb_back.sv
hw/rtl/ipv4_header_builder.sv
tb/ipv4_header_builder_test.sv
